// ----- design/mandelbrot_escape_time_pixel_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the escape-time pixel block.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_TOP_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_TOP_MACROS_SVH

// same-cycle implication
`define MET_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define MET_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- design/met_pkg.sv -----
// ----------------------------------------------------------------------------
// met_pkg
// Types, constants and helpers of the escape-time pixel block.
// ----------------------------------------------------------------------------
package met_pkg;

   localparam int COORD_BITS  = 32;
   localparam int STEP_BITS   = COORD_BITS - 1;
   localparam int COUNT_BITS  = 16;
   localparam int INDEX_BITS  = 12;
   localparam int FRAC_BITS   = 28;
   localparam int INT_BITS    = 8;
   localparam int WIDE_BITS   = FRAC_BITS + INT_BITS;
   localparam int MUL_BITS    = FRAC_BITS + 2;
   localparam int PROD_BITS   = 2 * MUL_BITS;
   localparam int SAT_IN_BITS = 46;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int COLOR_BITS  = 8;

   localparam logic [2:0] REG_MAX_ITER    = 3'd0;
   localparam logic [2:0] REG_ORIGIN_REAL = 3'd1;
   localparam logic [2:0] REG_ORIGIN_IMAG = 3'd2;
   localparam logic [2:0] REG_STEP_REAL   = 3'd3;
   localparam logic [2:0] REG_STEP_IMAG   = 3'd4;

   localparam logic [COUNT_BITS-1:0] RST_MAX_ITER = COUNT_BITS'(10000);
   localparam logic signed [COORD_BITS-1:0] RST_ORIGIN = COORD_BITS'(-536870912);
   localparam logic [STEP_BITS-1:0] RST_STEP = STEP_BITS'(262144);

   localparam logic signed [WIDE_BITS-1:0] WIDE_MAX = {1'b0, {(WIDE_BITS-1){1'b1}}};
   localparam logic signed [WIDE_BITS-1:0] WIDE_MIN = {1'b1, {(WIDE_BITS-1){1'b0}}};
   localparam logic signed [WIDE_BITS-1:0] TWO_FIX =
      WIDE_BITS'(1) << (FRAC_BITS + 1);
   localparam logic signed [WIDE_BITS-1:0] NEG_TWO_FIX = -TWO_FIX;
   localparam logic signed [PROD_BITS:0] FOUR_SQ =
      (PROD_BITS+1)'(1) << (2 * FRAC_BITS + 2);

   localparam logic [COLOR_BITS-1:0] RED_FULL = COLOR_BITS'(240);

   typedef struct packed {
      logic [COUNT_BITS-1:0]        max_iterations;
      logic signed [COORD_BITS-1:0] origin_real;
      logic signed [COORD_BITS-1:0] origin_imag;
      logic [STEP_BITS-1:0]         step_real;
      logic [STEP_BITS-1:0]         step_imag;
   } cfg_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] pixel_col;
      logic [INDEX_BITS-1:0] pixel_row;
   } req_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] iter_count;
      logic                  escaped;
      logic [COLOR_BITS-1:0] red;
      logic [COLOR_BITS-1:0] green_blue;
   } rsp_type;

   typedef struct packed {
      logic signed [WIDE_BITS-1:0] cr;
      logic signed [WIDE_BITS-1:0] ci;
   } point_type;

   function automatic logic signed [WIDE_BITS-1:0] sat_wide(
      input logic signed [SAT_IN_BITS-1:0] v);
      logic [SAT_IN_BITS-WIDE_BITS:0] upper;
      logic signed [WIDE_BITS-1:0]    r;
      upper = v[SAT_IN_BITS-1:WIDE_BITS-1];
      if ((&upper) || !(|upper)) begin
         r = v[WIDE_BITS-1:0];
      end else if (v[SAT_IN_BITS-1]) begin
         r = WIDE_MIN;
      end else begin
         r = WIDE_MAX;
      end
      return r;
   endfunction

endpackage

// ----- design/met_queue.sv -----
// ----------------------------------------------------------------------------
// met_queue
// Small first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module met_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] data_in,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] data_out,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full     = (cnt_ff == CNT_BITS'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= data_in;
      end
   end

endmodule

// ----- design/met_csr.sv -----
// ----------------------------------------------------------------------------
// met_csr
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module met_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [met_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [met_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [met_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                 pready,
   output met_pkg::cfg_type                     cfg
);

   met_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]       idx;
   logic             wr_en;

   assign idx    = paddr[met_pkg::CSR_ADDR_BITS-1:2];
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            met_pkg::REG_MAX_ITER:
               cfg_in.max_iterations = pwdata[met_pkg::COUNT_BITS-1:0];
            met_pkg::REG_ORIGIN_REAL:
               cfg_in.origin_real = pwdata[met_pkg::COORD_BITS-1:0];
            met_pkg::REG_ORIGIN_IMAG:
               cfg_in.origin_imag = pwdata[met_pkg::COORD_BITS-1:0];
            met_pkg::REG_STEP_REAL:
               cfg_in.step_real = pwdata[met_pkg::STEP_BITS-1:0];
            met_pkg::REG_STEP_IMAG:
               cfg_in.step_imag = pwdata[met_pkg::STEP_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         met_pkg::REG_MAX_ITER:
            prdata = met_pkg::CSR_DATA_BITS'(cfg_ff.max_iterations);
         met_pkg::REG_ORIGIN_REAL:
            prdata = met_pkg::CSR_DATA_BITS'(cfg_ff.origin_real);
         met_pkg::REG_ORIGIN_IMAG:
            prdata = met_pkg::CSR_DATA_BITS'(cfg_ff.origin_imag);
         met_pkg::REG_STEP_REAL:
            prdata = met_pkg::CSR_DATA_BITS'(cfg_ff.step_real);
         met_pkg::REG_STEP_IMAG:
            prdata = met_pkg::CSR_DATA_BITS'(cfg_ff.step_imag);
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_iterations <= met_pkg::RST_MAX_ITER;
         cfg_ff.origin_real    <= met_pkg::RST_ORIGIN;
         cfg_ff.origin_imag    <= met_pkg::RST_ORIGIN;
         cfg_ff.step_real      <= met_pkg::RST_STEP;
         cfg_ff.step_imag      <= met_pkg::RST_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- design/met_front.sv -----
// ----------------------------------------------------------------------------
// met_front
// Accept pixel items and map column and row to the point c.
// ----------------------------------------------------------------------------
module met_front (
   input  logic               clock,
   input  logic               reset,
   input  met_pkg::cfg_type   cfg,
   input  logic               push,
   input  met_pkg::req_type   req_data,
   output logic               full,
   output logic               pt_push,
   output met_pkg::point_type pt_data,
   input  logic               pt_full
);

   localparam int PROD_W = met_pkg::STEP_BITS + met_pkg::INDEX_BITS;

   logic                          valid_ff, valid_in;
   met_pkg::point_type            point_ff, point_in;
   logic [PROD_W-1:0]             prod_re, prod_im;
   logic signed [met_pkg::SAT_IN_BITS-1:0] sum_re, sum_im;
   logic                          accept;

   assign prod_re = PROD_W'(cfg.step_real) * PROD_W'(req_data.pixel_col);
   assign prod_im = PROD_W'(cfg.step_imag) * PROD_W'(req_data.pixel_row);
   assign sum_re  = met_pkg::SAT_IN_BITS'(cfg.origin_real)
                  + $signed(met_pkg::SAT_IN_BITS'(prod_re));
   assign sum_im  = met_pkg::SAT_IN_BITS'(cfg.origin_imag)
                  + $signed(met_pkg::SAT_IN_BITS'(prod_im));

   assign full    = valid_ff && pt_full;
   assign accept  = push && !full;
   assign pt_push = valid_ff && !pt_full;
   assign pt_data = point_ff;

   always_comb begin
      valid_in    = valid_ff;
      point_in    = point_ff;
      point_in.cr = met_pkg::sat_wide(sum_re);
      point_in.ci = met_pkg::sat_wide(sum_im);
      if (accept) begin
         valid_in = 1'b1;
      end else if (pt_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         point_ff <= point_in;
      end
   end

endmodule

// ----- design/met_back.sv -----
// ----------------------------------------------------------------------------
// met_back
// Iterate z = z*z + c for one point and build the result item.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_pixel_top_macros.svh"

module met_back (
   input  logic               clock,
   input  logic               reset,
   input  met_pkg::cfg_type   cfg,
   input  logic               pt_empty,
   input  met_pkg::point_type pt_data,
   output logic               pt_pop,
   input  logic               rs_full,
   output logic               rs_push,
   output met_pkg::rsp_type   rs_data
);

   localparam int W  = met_pkg::WIDE_BITS;
   localparam int PW = met_pkg::PROD_BITS;
   localparam int SW = met_pkg::SAT_IN_BITS;
   localparam int CW = met_pkg::COUNT_BITS;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_ADD  = 4'b0100,
      ST_DONE = 4'b1000
   } back_state_type;

   back_state_type state_ff, state_in;

   logic signed [W-1:0]  cr_ff, cr_in, ci_ff, ci_in;
   logic signed [W-1:0]  x_ff, x_in, y_ff, y_in;
   logic [CW-1:0]        count_ff, count_in;
   logic signed [PW-1:0] pxx_ff, pxx_in, pyy_ff, pyy_in, pxy_ff, pxy_in;

   logic signed [met_pkg::MUL_BITS-1:0] xm, ym;
   logic signed [PW:0]   sumsq;
   logic signed [W-1:0]  x_new, y_new;
   logic                 out_prod, out_new, at_limit, esc;
   logic [met_pkg::COLOR_BITS-1:0] low;

   assign xm = x_ff[met_pkg::MUL_BITS-1:0];
   assign ym = y_ff[met_pkg::MUL_BITS-1:0];
   assign pxx_in = xm * xm;
   assign pyy_in = ym * ym;
   assign pxy_in = xm * ym;

   assign sumsq = (PW+1)'(pxx_ff) + (PW+1)'(pyy_ff);
   assign out_prod = (sumsq >= met_pkg::FOUR_SQ);
   assign at_limit = (count_ff == cfg.max_iterations);
   assign x_new = met_pkg::sat_wide(SW'(pxx_ff >>> met_pkg::FRAC_BITS)
                                  - SW'(pyy_ff >>> met_pkg::FRAC_BITS) + SW'(cr_ff));
   assign y_new = met_pkg::sat_wide(SW'(pxy_ff >>> (met_pkg::FRAC_BITS - 1))
                                  + SW'(ci_ff));
   assign out_new = (x_new >= met_pkg::TWO_FIX) || (x_new <= met_pkg::NEG_TWO_FIX)
                 || (y_new >= met_pkg::TWO_FIX) || (y_new <= met_pkg::NEG_TWO_FIX);

   assign pt_pop  = (state_ff == ST_IDLE) && !pt_empty;
   assign rs_push = (state_ff == ST_DONE) && !rs_full;

   assign esc = (count_ff != cfg.max_iterations);
   assign low = {count_ff[3:0], 4'b0000};
   always_comb begin
      rs_data.iter_count = count_ff;
      rs_data.escaped    = esc;
      rs_data.red        = '0;
      rs_data.green_blue = '0;
      if (esc) begin
         if (count_ff[4]) begin
            rs_data.red        = met_pkg::RED_FULL;
            rs_data.green_blue = low;
         end else begin
            rs_data.red = low;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!pt_empty) begin
               cr_in    = pt_data.cr;
               ci_in    = pt_data.ci;
               x_in     = '0;
               y_in     = '0;
               count_in = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (out_prod || at_limit) begin
               state_in = ST_DONE;
            end else begin
               x_in     = x_new;
               y_in     = y_new;
               count_in = count_ff + 1'b1;
               state_in = out_new ? ST_DONE : ST_MUL;
            end
         end
         ST_DONE: begin
            if (!rs_full) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cr_ff    <= cr_in;
      ci_ff    <= ci_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      count_ff <= count_in;
      if (state_ff == ST_MUL) begin
         pxx_ff <= pxx_in;
         pyy_ff <= pyy_in;
         pxy_ff <= pxy_in;
      end
   end

   `MET_ASSERT_NXT(a_mul_to_add, clock, reset, state_ff == ST_MUL, state_ff == ST_ADD)
   `MET_ASSERT_IMP(a_mul_in_disk, clock, reset, state_ff == ST_MUL, (x_ff < met_pkg::TWO_FIX) && (x_ff > met_pkg::NEG_TWO_FIX) && (y_ff < met_pkg::TWO_FIX) && (y_ff > met_pkg::NEG_TWO_FIX))
   `MET_ASSERT_NXT(a_pop_starts, clock, reset, pt_pop, state_ff == ST_MUL && count_ff == '0)

endmodule

// ----- design/mandelbrot_escape_time_pixel_top.sv -----
// Flow: the front and the point queue take new pixels while the back end iterates;
// the back end starts the next point only once its last result is pushed. Each step of the shared
// multiply/add iteration loop has a multiply state and then an add state.
// Reset: synchronous, active high; clears queues and control, loads the
// configuration registers with their defaults.
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_top
// Escape-time pixel engine: front maps pixels to points, back iterates.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_top #(
   parameter int PT_DEPTH = 2,
   parameter int RS_DEPTH = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  met_pkg::req_type                  req_data,
   output logic                              full,
   output logic                              empty,
   input  logic                              pop,
   output met_pkg::rsp_type                  rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [met_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [met_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [met_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                              pready
);

   localparam int PT_W = $bits(met_pkg::point_type);
   localparam int RS_W = $bits(met_pkg::rsp_type);

   met_pkg::cfg_type   cfg;
   met_pkg::point_type pt_wdata, pt_rdata;
   met_pkg::rsp_type   rs_wdata;
   logic [PT_W-1:0]    pt_rvec;
   logic [RS_W-1:0]    rs_rvec;
   logic               pt_push, pt_full, pt_pop, pt_empty;
   logic               rs_push, rs_full;

   assign pt_rdata = pt_rvec;
   assign rsp_data = rs_rvec;

   met_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   met_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .pt_push  (pt_push),
      .pt_data  (pt_wdata),
      .pt_full  (pt_full)
   );

   met_queue #(
      .WIDTH (PT_W),
      .DEPTH (PT_DEPTH)
   ) u_pt_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (pt_push),
      .data_in  (PT_W'(pt_wdata)),
      .full     (pt_full),
      .pop      (pt_pop),
      .data_out (pt_rvec),
      .empty    (pt_empty)
   );

   met_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .pt_empty (pt_empty),
      .pt_data  (pt_rdata),
      .pt_pop   (pt_pop),
      .rs_full  (rs_full),
      .rs_push  (rs_push),
      .rs_data  (rs_wdata)
   );

   met_queue #(
      .WIDTH (RS_W),
      .DEPTH (RS_DEPTH)
   ) u_rs_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rs_push),
      .data_in  (RS_W'(rs_wdata)),
      .full     (rs_full),
      .pop      (pop),
      .data_out (rs_rvec),
      .empty    (empty)
   );

endmodule

// ----- verif/mandelbrot_escape_time_pixel_top_test.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_top_test
// Self-checking testbench for the escape-time pixel engine. The initial block
// programs the view through the register port and queues pixels. The clocked
// driver pushes them with random gaps. The clocked monitor pops results with
// random stalls and compares each field against a fixed-point escape-time
// calculation made when the pixel was accepted.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import met_pkg::*;

   localparam logic [2:0] REG_UNUSED = 3'd6;
   localparam longint Q8_HI   = (longint'(1) <<< (WIDE_BITS - 1)) - 1;
   localparam longint Q8_LO   = -(longint'(1) <<< (WIDE_BITS - 1));
   localparam longint Q8_TWO  = longint'(2) <<< FRAC_BITS;
   localparam longint Q8_FOUR = longint'(4) <<< (2 * FRAC_BITS);

   typedef struct {
      req_type pixel;
      bit      hold;
   } pixel_job_t;

   logic                     clock   = 1'b0;
   logic                     reset   = 1'b1;
   logic                     push    = 1'b0;
   req_type                  req_data = '0;
   logic                     full;
   logic                     empty;
   logic                     pop     = 1'b0;
   rsp_type                  rsp_data;
   logic                     psel    = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr   = '0;
   logic [CSR_DATA_BITS-1:0] pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   cfg_type     view;
   pixel_job_t  pending[$];
   rsp_type     pixel_expect[$];
   int unsigned queued_count   = 0;
   int unsigned accepted_count = 0;
   int unsigned send_gap_max   = 19;
   int unsigned recv_gap_max   = 19;
   int unsigned send_wait      = 0;
   int unsigned recv_wait      = 0;
   int unsigned fail_count     = 0;
   int unsigned checked_count  = 0;
   int unsigned escaped_count  = 0;
   int unsigned setting_count  = 0;

   mandelbrot_escape_time_pixel_top DUT (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #5 clock = ~clock;

   function automatic longint clamp_q8(longint v);
      if (v > Q8_HI) begin
         return Q8_HI;
      end
      if (v < Q8_LO) begin
         return Q8_LO;
      end
      return v;
   endfunction

   function automatic rsp_type escape_time(req_type px);
      longint                cr, ci, x, y, xx, yy, xy2;
      int unsigned           count;
      bit                    outside;
      bit                    esc;
      logic [COLOR_BITS-1:0] low;
      rsp_type               r;
      cr = clamp_q8(longint'(signed'(view.origin_real))
                    + longint'(px.pixel_col) * longint'(view.step_real));
      ci = clamp_q8(longint'(signed'(view.origin_imag))
                    + longint'(px.pixel_row) * longint'(view.step_imag));
      x = 0;
      y = 0;
      count = 0;
      outside = 1'b0;
      while (count < view.max_iterations && !outside) begin
         xx  = (x * x) >>> FRAC_BITS;
         yy  = (y * y) >>> FRAC_BITS;
         xy2 = (2 * x * y) >>> FRAC_BITS;
         x = clamp_q8(xx - yy + cr);
         y = clamp_q8(xy2 + ci);
         outside = (x >= Q8_TWO) || (x <= -Q8_TWO) || (y >= Q8_TWO) || (y <= -Q8_TWO)
                   || (x * x + y * y >= Q8_FOUR);
         count++;
      end
      esc = (count != view.max_iterations);
      low = COLOR_BITS'((count & 15) * 16);
      r.iter_count = COUNT_BITS'(count);
      r.escaped    = esc;
      r.red        = !esc ? '0 : (count[4] ? RED_FULL : low);
      r.green_blue = (esc && count[4]) ? low : '0;
      return r;
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_MAX_ITER:    view.max_iterations = value[COUNT_BITS-1:0];
         REG_ORIGIN_REAL: view.origin_real    = value;
         REG_ORIGIN_IMAG: view.origin_imag    = value;
         REG_STEP_REAL:   view.step_real      = value[STEP_BITS-1:0];
         REG_STEP_IMAG:   view.step_imag      = value[STEP_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic load_view(input logic [31:0] limit, input logic [31:0] o_re,
                            input logic [31:0] o_im, input logic [31:0] s_re,
                            input logic [31:0] s_im);
      csr_write(REG_MAX_ITER, limit);
      csr_write(REG_ORIGIN_REAL, o_re);
      csr_write(REG_ORIGIN_IMAG, o_im);
      csr_write(REG_STEP_REAL, s_re);
      csr_write(REG_STEP_IMAG, s_im);
      setting_count++;
   endtask

   task automatic queue_pixel(input int unsigned col, input int unsigned row, input bit hold);
      pixel_job_t job;
      job.pixel.pixel_col = INDEX_BITS'(col);
      job.pixel.pixel_row = INDEX_BITS'(row);
      job.hold = hold;
      pending.push_back(job);
      queued_count++;
   endtask

   task automatic wait_idle();
      while (accepted_count != queued_count || pixel_expect.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin : pixel_driver
      if (reset) begin
         push      <= 1'b0;
         send_wait <= 0;
      end else begin
         if (push && !full) begin
            pixel_expect.push_back(escape_time(req_data));
            accepted_count++;
         end
         if (!push || !full) begin
            if (send_wait != 0) begin
               push      <= 1'b0;
               send_wait <= send_wait - 1;
            end else if (pending.size() != 0
                         && !(pending[0].hold && pixel_expect.size() != 0)) begin
               req_data  <= pending[0].pixel;
               push      <= 1'b1;
               send_wait <= $urandom_range(0, send_gap_max);
               pending.pop_front();
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      rsp_type     want;
      int unsigned stall;
      if (reset) begin
         pop       <= 1'b0;
         recv_wait <= 0;
      end else if (pop && !empty) begin
         if (pixel_expect.size() == 0) begin
            $error("unexpected item: iter_count %0d escaped %0d", rsp_data.iter_count,
                   rsp_data.escaped);
            fail_count++;
         end else begin
            want = pixel_expect.pop_front();
            checked_count++;
            if (want.escaped) begin
               escaped_count++;
            end
            if (rsp_data.iter_count !== want.iter_count) begin
               $error("iter_count: expected %0d, got %0d", want.iter_count, rsp_data.iter_count);
               fail_count++;
            end
            if (rsp_data.escaped !== want.escaped) begin
               $error("escaped: expected %0d, got %0d", want.escaped, rsp_data.escaped);
               fail_count++;
            end
            if (rsp_data.red !== want.red) begin
               $error("red: expected %0d, got %0d", want.red, rsp_data.red);
               fail_count++;
            end
            if (rsp_data.green_blue !== want.green_blue) begin
               $error("green_blue: expected %0d, got %0d", want.green_blue,
                      rsp_data.green_blue);
               fail_count++;
            end
         end
         stall = $urandom_range(0, recv_gap_max);
         recv_wait <= stall;
         pop       <= (stall == 0);
      end else if (recv_wait != 0) begin
         recv_wait <= recv_wait - 1;
         pop       <= (recv_wait == 1);
      end else begin
         pop <= 1'b1;
      end
   end

   initial begin : stimulus
      logic [31:0] limit, o_re, o_im, s_re, s_im;
      view.max_iterations = RST_MAX_ITER;
      view.origin_real    = RST_ORIGIN;
      view.origin_imag    = RST_ORIGIN;
      view.step_real      = RST_STEP;
      view.step_imag      = RST_STEP;
      setting_count = 1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset view: the four corners and the center point
      queue_pixel(0, 0, 1'b0);
      queue_pixel(4095, 4095, 1'b0);
      queue_pixel(2048, 2048, 1'b0);
      queue_pixel(0, 4095, 1'b0);
      queue_pixel(4095, 0, 1'b0);
      wait_idle();

      // zero iteration limit
      csr_write(REG_MAX_ITER, 32'd0);
      setting_count++;
      queue_pixel(2048, 2048, 1'b0);
      queue_pixel(1, 1, 1'b0);
      wait_idle();

      // c = 1.0: escape lands exactly on the limit, then one below it
      load_view(32'd2, 32'h1000_0000, 32'd0, 32'd0, 32'd0);
      queue_pixel(0, 0, 1'b0);
      wait_idle();
      csr_write(REG_MAX_ITER, 32'd3);
      setting_count++;
      queue_pixel(5, 7, 1'b0);
      wait_idle();

      // saturated coordinates at the register extremes
      load_view(32'd65535, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      csr_write(REG_UNUSED, 32'h0000_0001);
      queue_pixel(0, 0, 1'b0);
      queue_pixel(4095, 4095, 1'b0);
      queue_pixel(4095, 0, 1'b0);
      queue_pixel(0, 4095, 1'b0);
      queue_pixel(12'hAAA, 12'h555, 1'b0);
      wait_idle();

      // inside point at the largest limit, then at a limit of one
      load_view(32'd65535, 32'd0, 32'd0, 32'd0, 32'd0);
      queue_pixel(4095, 4095, 1'b0);
      wait_idle();
      csr_write(REG_MAX_ITER, 32'd1);
      setting_count++;
      queue_pixel(100, 200, 1'b0);
      wait_idle();

      for (int b = 0; b < 20; b++) begin
         case ($urandom_range(0, 3))
            0:       limit = $urandom_range(1, 8);
            3:       limit = $urandom_range(1, 255);
            default: limit = $urandom_range(1, 48);
         endcase
         if ($urandom_range(0, 4) == 0) begin
            o_re = $urandom;
            o_im = $urandom;
         end else begin
            o_re = $urandom_range(0, 805306368) - 671088640;
            o_im = $urandom_range(0, 536870912) - 402653184;
         end
         case ($urandom_range(0, 3))
            0: begin
               s_re = 32'd262144;
               s_im = 32'd262144;
            end
            1: begin
               s_re = $urandom_range(1 << 10, 1 << 19);
               s_im = $urandom_range(1 << 10, 1 << 19);
            end
            2: begin
               s_re = $urandom_range(0, 1 << 14);
               s_im = $urandom_range(0, 1 << 14);
            end
            default: begin
               s_re = $urandom & 32'h7FFF_FFFF;
               s_im = $urandom & 32'h7FFF_FFFF;
            end
         endcase
         load_view(limit, o_re, o_im, s_re, s_im);
         send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
         recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
         for (int k = 0; k < 29; k++) begin
            queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095),
                        (b == 0 && k == 10) || ($urandom_range(0, 39) == 0));
         end
         wait_idle();
      end

      repeat (40) @(posedge clock);
      $display("%0d pixel items checked over %0d register settings, %0d escaped",
               checked_count, setting_count, escaped_count);
      $display("covered zero and full limits, saturated views and escape on the limit");
      if (fail_count == 0 && pixel_expect.size() == 0) begin
         $display("mandelbrot_escape_time_pixel_top: match");
      end else begin
         $display("mandelbrot_escape_time_pixel_top: mismatch");
      end
      $finish;
   end

   initial begin : watchdog
      #25_000_000;
      $display("mandelbrot_escape_time_pixel_top: mismatch");
      $finish;
   end

endmodule
